/* rtl/core/fbfla_pkg.sv */
`default_nettype none

package fbfla_pkg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    localparam logic [15:0] BLOCK_BYTES_RESET = 16'd64;
    localparam logic [31:0] INVALID_MAX       = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

/* rtl/core/fixed_block_free_list_allocator_top.sv */
// An accepted item is captured alongside the synchronous read of the link memory; the
// result is written to the output register in the update state, with the write-back.
// A new item is taken only after the read-modify-write of the previous one (synchronous
// read, then update and write-back of the link memory) is through.
// A result waiting in the output register holds the update cycle until it is taken.
// Reset (synchronous, active low) is ready at once: blocks never handed out are
// tracked by a fill mark, so the memory needs no clearing pass.
`default_nettype none

module fixed_block_free_list_allocator_top #(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,

    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_request_bytes,
    input  wire logic [7:0]  i_block_index,

    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_granted_index,
    output logic [8:0]       o_free_blocks,
    output logic [31:0]      o_invalid_frees
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_BLOCKS - 1);
    localparam logic [CW-1:0] CNT_RESET = CW'(NUM_BLOCKS);

    // Each memory word holds the allocated mark on top of the next link.
    logic [IW:0] r_mem [NUM_BLOCKS];
    logic [IW:0] r_rd_data;

    fbfla_pkg::t_state  r_state, n_state;
    fbfla_pkg::t_opcode r_op;
    logic [15:0]        r_req;
    logic               r_idx_ok;
    logic [IW-1:0]      r_addr;
    logic               r_rd_fresh;

    logic [IW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [31:0]   r_invalid, n_invalid;
    logic [15:0]   r_block_bytes;

    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [7:0]  r_out_granted;
    logic [8:0]  r_out_free;
    logic [31:0] r_out_invalid;

    logic               accept;
    logic               do_exec;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      link;
    logic               mark;
    logic               too_large;
    logic               mem_we;
    logic [IW:0]        mem_wdata;
    fbfla_pkg::t_status status;
    logic [IW-1:0]      granted;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fbfla_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = fbfla_pkg::S_EXEC;
                end
            end
            fbfla_pkg::S_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    n_state = fbfla_pkg::S_IDLE;
                end
            end
            default: n_state = fbfla_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_ready = 1'b0;
        do_exec = 1'b0;
        unique case (r_state)
            fbfla_pkg::S_IDLE: o_ready = 1'b1;
            fbfla_pkg::S_EXEC: do_exec = !r_out_valid || i_ready;
            default: begin
                o_ready = 1'b0;
                do_exec = 1'b0;
            end
        endcase
    end

    assign accept  = i_valid && o_ready;
    assign rd_addr = (i_opcode == fbfla_pkg::OP_FREE) ? IW'(i_block_index) : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbfla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item and the fill-mark test alongside the memory read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= fbfla_pkg::t_opcode'(i_opcode);
            r_req      <= i_request_bytes;
            r_idx_ok   <= 32'(i_block_index) < NUM_BLOCKS;
            r_addr     <= rd_addr;
            r_rd_fresh <= CW'(rd_addr) >= r_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Entries at or above the fill mark were never handed out and still hold
    // their reset contents: unmarked, linked to the following block (the last one to block 0).
    always_comb begin
        if (r_rd_fresh) begin
            link = (r_addr == LAST_IDX) ? '0 : r_addr + IW'(1);
            mark = 1'b0;
        end else begin
            link = r_rd_data[IW-1:0];
            mark = r_rd_data[IW];
        end
    end

    assign too_large = r_req > r_block_bytes;

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_fresh   = r_fresh;
        n_invalid = r_invalid;
        status    = fbfla_pkg::ST_OK;
        granted   = '0;
        mem_we    = 1'b0;
        mem_wdata = {1'b0, r_head};
        if (r_op == fbfla_pkg::OP_ALLOC) begin
            priority if (too_large) begin
                status = fbfla_pkg::ST_TOO_LARGE;
            end else if (r_count == '0) begin
                status = fbfla_pkg::ST_EXHAUSTED;
            end else begin
                granted   = r_addr;
                n_head    = link;
                n_count   = r_count - CW'(1);
                mem_we    = do_exec;
                mem_wdata = {1'b1, link};
                if (r_rd_fresh) begin
                    n_fresh = r_fresh + CW'(1);
                end
            end
        end else begin
            if (!r_idx_ok || !mark || too_large) begin
                status = fbfla_pkg::ST_BAD_FREE;
                if (r_invalid != fbfla_pkg::INVALID_MAX) begin
                    n_invalid = r_invalid + 32'd1;
                end
            end else begin
                n_head    = r_addr;
                n_count   = r_count + CW'(1);
                mem_we    = do_exec;
                mem_wdata = {1'b0, r_head};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_count       <= CNT_RESET;
            r_fresh       <= '0;
            r_invalid     <= '0;
            r_block_bytes <= fbfla_pkg::BLOCK_BYTES_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_block_bytes <= i_cfg_wr_data;
            end
            if (do_exec) begin
                r_head      <= n_head;
                r_count     <= n_count;
                r_fresh     <= n_fresh;
                r_invalid   <= n_invalid;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_exec) begin
            r_out_status  <= status;
            r_out_granted <= 8'(granted);
            r_out_free    <= 9'(n_count);
            r_out_invalid <= n_invalid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_granted;
    assign o_free_blocks   = r_out_free;
    assign o_invalid_frees = r_out_invalid;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_BLOCKS = 256;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        fbfla_pkg::t_status status;
        logic [7:0]         granted;
        logic [8:0]         free_blocks;
        logic [31:0]        invalid_frees;
    } t_alloc_result;

    typedef enum {
        UNTIL_EXHAUSTED,
        UNTIL_REFILLED,
        FIXED_COUNT
    } t_phase_goal;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [15:0] i_cfg_wr_data   = '0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic        i_opcode        = 1'b0;
    logic [15:0] i_request_bytes = '0;
    logic [7:0]  i_block_index   = '0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [1:0]  o_status;
    logic [7:0]  o_granted_index;
    logic [8:0]  o_free_blocks;
    logic [31:0] o_invalid_frees;

    // Shadow copy of the pool: free list links, allocation marks and counters.
    logic [7:0]  link_mem [POOL_BLOCKS];
    bit          held_mark [POOL_BLOCKS];
    logic [7:0]  head_blk;
    int          free_cnt;
    logic [31:0] bad_frees;
    logic [15:0] blk_limit;

    t_alloc_result expected_results [$];
    t_alloc_result want;

    int pred_status_count [4];
    int status_hits [4];
    int fail_count = 0;
    int items_sent = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The test asks for a hold-off by bumping hold_req_id; the receiver counts it down.
    int hold_len     = 0;
    int hold_req_id  = 0;
    int hold_seen_id = 0;
    int hold_left    = 0;

    fixed_block_free_list_allocator_top #(
        .NUM_BLOCKS(POOL_BLOCKS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_request_bytes (i_request_bytes),
        .i_block_index   (i_block_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_blocks   (o_free_blocks),
        .o_invalid_frees (o_invalid_frees)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id <= hold_req_id;
            hold_left    <= hold_len;
            i_ready      <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: status %0d", o_status);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_granted_index !== want.granted) begin
                    $error("granted_index: expected %0d, actual %0d",
                           want.granted, o_granted_index);
                    fail_count++;
                end
                if (o_free_blocks !== want.free_blocks) begin
                    $error("free_blocks: expected %0d, actual %0d",
                           want.free_blocks, o_free_blocks);
                    fail_count++;
                end
                if (o_invalid_frees !== want.invalid_frees) begin
                    $error("invalid_frees: expected %0d, actual %0d",
                           want.invalid_frees, o_invalid_frees);
                    fail_count++;
                end
                status_hits[o_status]++;
            end
        end
    end

    function automatic void reset_pool_model();
        for (int i = 0; i < POOL_BLOCKS; i++) begin
            link_mem[i]  = 8'(i + 1);
            held_mark[i] = 1'b0;
        end
        head_blk  = '0;
        free_cnt  = POOL_BLOCKS;
        bad_frees = '0;
        blk_limit = fbfla_pkg::BLOCK_BYTES_RESET;
    endfunction

    function automatic t_alloc_result predict_alloc_step(fbfla_pkg::t_opcode op,
                                                         logic [15:0] req,
                                                         logic [7:0] idx);
        t_alloc_result r;
        r.status  = fbfla_pkg::ST_OK;
        r.granted = '0;
        if (op == fbfla_pkg::OP_ALLOC) begin
            // The size check wins over an empty pool.
            if (req > blk_limit) begin
                r.status = fbfla_pkg::ST_TOO_LARGE;
            end else if (free_cnt == 0) begin
                r.status = fbfla_pkg::ST_EXHAUSTED;
            end else begin
                r.granted          = head_blk;
                head_blk           = link_mem[head_blk];
                free_cnt--;
                held_mark[r.granted] = 1'b1;
            end
        end else begin
            if (!held_mark[idx] || req > blk_limit) begin
                r.status = fbfla_pkg::ST_BAD_FREE;
                if (bad_frees != fbfla_pkg::INVALID_MAX) begin
                    bad_frees++;
                end
            end else begin
                held_mark[idx] = 1'b0;
                link_mem[idx]  = head_blk;
                head_blk       = idx;
                free_cnt++;
            end
        end
        r.free_blocks   = 9'(free_cnt);
        r.invalid_frees = bad_frees;
        pred_status_count[r.status]++;
        return r;
    endfunction

    // Returns some block that is currently handed out, or a random one if none is.
    function automatic logic [7:0] pick_held();
        int start;
        int j;
        start = $urandom_range(POOL_BLOCKS - 1);
        for (int k = 0; k < POOL_BLOCKS; k++) begin
            j = (start + k) % POOL_BLOCKS;
            if (held_mark[j]) begin
                return 8'(j);
            end
        end
        return 8'(start);
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 85) begin
            return 16'($urandom_range(blk_limit, 0));
        end
        if (r < 95 && blk_limit != 16'hFFFF) begin
            return 16'($urandom_range(65535, int'(blk_limit) + 1));
        end
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_item(input fbfla_pkg::t_opcode op, input logic [15:0] req,
                             input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_request_bytes <= req;
        i_block_index   <= idx;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        expected_results.insert(expected_results.size(), predict_alloc_step(op, req, idx));
        items_sent++;
    endtask

    task automatic send_random_item(input int alloc_pct);
        fbfla_pkg::t_opcode op;
        logic [15:0]        req;
        logic [7:0]         idx;
        if ($urandom_range(99) < alloc_pct) begin
            op  = fbfla_pkg::OP_ALLOC;
            idx = 8'($urandom_range(255));
            req = pick_size();
        end else begin
            op = fbfla_pkg::OP_FREE;
            if (free_cnt < POOL_BLOCKS && $urandom_range(99) < 80) begin
                idx = pick_held();
                req = 16'($urandom_range(blk_limit, 0));
            end else begin
                // Mostly double or wild frees, sometimes with an oversized claim.
                idx = 8'($urandom_range(255));
                req = pick_size();
            end
        end
        send_item(op, req, idx);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_block_bytes(input logic [15:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        blk_limit = value;
        cfg_writes++;
    endtask

    task automatic run_phase(input logic [15:0] blk, input int send_pct, input int stall_pct,
                             input int alloc_pct, input int min_items,
                             input t_phase_goal goal);
        int n;
        int ex_start;
        write_block_bytes(blk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        ex_start       = pred_status_count[fbfla_pkg::ST_EXHAUSTED];
        n              = 0;
        while (n < 2000) begin
            send_random_item(alloc_pct);
            n++;
            if (n >= min_items) begin
                if (goal == FIXED_COUNT) break;
                if (goal == UNTIL_EXHAUSTED &&
                    pred_status_count[fbfla_pkg::ST_EXHAUSTED] - ex_start >= 20) break;
                if (goal == UNTIL_REFILLED && free_cnt >= POOL_BLOCKS - 6) break;
            end
        end
    endtask

    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(fbfla_pkg::OP_ALLOC, 16'd0, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd64, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd65, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'hFFFF, 8'd255);
        send_item(fbfla_pkg::OP_FREE, 16'd64, 8'd1);
        send_item(fbfla_pkg::OP_FREE, 16'd64, 8'd1);
        send_item(fbfla_pkg::OP_FREE, 16'd0, 8'd255);
        send_item(fbfla_pkg::OP_FREE, 16'd65, 8'd0);
        send_item(fbfla_pkg::OP_FREE, 16'hFFFF, 8'd0);
        send_item(fbfla_pkg::OP_FREE, 16'd0, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd16, 8'hAA);
        send_item(fbfla_pkg::OP_ALLOC, 16'd1, 8'h55);
        send_item(fbfla_pkg::OP_ALLOC, 16'd2, 8'd0);
        send_item(fbfla_pkg::OP_FREE, 16'd32, 8'd2);
        send_item(fbfla_pkg::OP_FREE, 16'd63, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd8, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd8, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd8, 8'd0);
    endtask

    task automatic test_block_size_extremes();
        write_block_bytes(16'd8);
        send_item(fbfla_pkg::OP_ALLOC, 16'd8, 8'd0);
        send_item(fbfla_pkg::OP_ALLOC, 16'd9, 8'd0);
        send_item(fbfla_pkg::OP_FREE, 16'd9, pick_held());
        send_item(fbfla_pkg::OP_FREE, 16'd8, pick_held());
        write_block_bytes(16'hFFFF);
        send_item(fbfla_pkg::OP_ALLOC, 16'hFFFF, 8'd255);
        send_item(fbfla_pkg::OP_FREE, 16'hFFFF, pick_held());
        send_item(fbfla_pkg::OP_ALLOC, 16'd0, 8'd0);
    endtask

    task automatic test_pool_cycling();
        run_phase(16'hFFFF, 0, 0, 95, 200, UNTIL_EXHAUSTED);
        run_phase(16'($urandom_range(1024, 8)), 52, 0, 10, 200, UNTIL_REFILLED);
        run_phase(16'd8, 0, 52, 95, 200, UNTIL_EXHAUSTED);
        run_phase(16'($urandom_range(65535, 8)), 18, 18, 50, 150, FIXED_COUNT);
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // output register fills and the input side has to stall.
    task automatic test_output_backpressure();
        write_block_bytes(fbfla_pkg::BLOCK_BYTES_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len    <= 400;
        hold_req_id <= hold_req_id + 1;
        for (int i = 0; i < 40; i++) begin
            send_random_item(50);
        end
    endtask

    initial begin
        reset_pool_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_block_size_extremes();
        test_pool_cycling();
        test_output_backpressure();

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d items across %0d block size settings and four idle mixes.",
                 items_sent, cfg_writes);
        $display("Results: %0d granted or freed, %0d exhausted, %0d too large, %0d bad frees.",
                 status_hits[fbfla_pkg::ST_OK], status_hits[fbfla_pkg::ST_EXHAUSTED],
                 status_hits[fbfla_pkg::ST_TOO_LARGE], status_hits[fbfla_pkg::ST_BAD_FREE]);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
